// ===== design/mbdgs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbdgs_pkg
// shared types, byte slot codes and the crc-16 step for the data group
// segmenter
// ----------------------------------------------------------------------------
package mbdgs_pkg;

    localparam int SIZE_BITS = 24;
    localparam int SEG_BITS  = 13;
    localparam int SNUM_BITS = 15;

    localparam logic [SEG_BITS-1:0] MAX_SEG_RESET = 13'd1013;
    localparam logic [SEG_BITS-1:0] SEG_LEN_MIN   = 13'd1;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_BODY  = 1'b1;

    localparam logic [7:0]  HDR_TYPE_BYTE = 8'h74;
    localparam logic [7:0]  HDR_EXT_BYTE  = 8'h12;
    localparam logic [15:0] CRC_PRESET    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;

    // byte slot within one result burst
    localparam logic [3:0] IDX_TYPE    = 4'd0;
    localparam logic [3:0] IDX_CONT    = 4'd1;
    localparam logic [3:0] IDX_SNUM_HI = 4'd2;
    localparam logic [3:0] IDX_SNUM_LO = 4'd3;
    localparam logic [3:0] IDX_EXT     = 4'd4;
    localparam logic [3:0] IDX_TID_HI  = 4'd5;
    localparam logic [3:0] IDX_TID_LO  = 4'd6;
    localparam logic [3:0] IDX_LEN_HI  = 4'd7;
    localparam logic [3:0] IDX_LEN_LO  = 4'd8;
    localparam logic [3:0] IDX_DATA    = 4'd9;
    localparam logic [3:0] IDX_CRC_HI  = 4'd10;
    localparam logic [3:0] IDX_CRC_LO  = 4'd11;

    typedef struct packed {
        logic                 has_hdr;
        logic                 has_crc;
        logic [3:0]           cont;
        logic                 last;
        logic [SNUM_BITS-1:0] seg_num;
        logic [15:0]          tid;
        logic [SEG_BITS-1:0]  seg_len;
        logic [7:0]           data;
    } burst_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/mbdgs_emit.sv =====
// ----------------------------------------------------------------------------
// mbdgs_emit
// holds one result burst and sends it a beat at a time: header (on a segment's
// first byte), body byte and crc (on its last), running the crc over each header and body beat as it leaves
// ----------------------------------------------------------------------------
module mbdgs_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  mbdgs_pkg::burst_t burst,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_group_end,
    output logic              m_run_last
);

    logic              busy_reg, busy_next;
    logic [3:0]        idx_reg, idx_next;
    logic [15:0]       crc_reg, crc_next;
    mbdgs_pkg::burst_t desc_reg;
    logic              beat;
    logic              last_beat;
    logic [15:0]       crc_base;

    assign last_beat = (idx_reg == mbdgs_pkg::IDX_CRC_LO) ||
                       ((idx_reg == mbdgs_pkg::IDX_DATA) && !desc_reg.has_crc);
    assign beat      = busy_reg && m_ready;
    assign free      = !busy_reg || (m_ready && last_beat);

    assign m_valid     = busy_reg;
    assign m_run_last  = last_beat;
    assign m_group_end = (idx_reg == mbdgs_pkg::IDX_CRC_LO);

    always_comb begin
        case (idx_reg)
            mbdgs_pkg::IDX_TYPE:    m_out_byte = mbdgs_pkg::HDR_TYPE_BYTE;
            mbdgs_pkg::IDX_CONT:    m_out_byte = {desc_reg.cont, 4'h0};
            mbdgs_pkg::IDX_SNUM_HI: m_out_byte = {desc_reg.last, desc_reg.seg_num[14:8]};
            mbdgs_pkg::IDX_SNUM_LO: m_out_byte = desc_reg.seg_num[7:0];
            mbdgs_pkg::IDX_EXT:     m_out_byte = mbdgs_pkg::HDR_EXT_BYTE;
            mbdgs_pkg::IDX_TID_HI:  m_out_byte = desc_reg.tid[15:8];
            mbdgs_pkg::IDX_TID_LO:  m_out_byte = desc_reg.tid[7:0];
            mbdgs_pkg::IDX_LEN_HI:  m_out_byte = {3'b000, desc_reg.seg_len[12:8]};
            mbdgs_pkg::IDX_LEN_LO:  m_out_byte = desc_reg.seg_len[7:0];
            mbdgs_pkg::IDX_DATA:    m_out_byte = desc_reg.data;
            mbdgs_pkg::IDX_CRC_HI:  m_out_byte = ~crc_reg[15:8];
            mbdgs_pkg::IDX_CRC_LO:  m_out_byte = ~crc_reg[7:0];
            default:                m_out_byte = 8'h00;
        endcase
    end

    // crc restarts on the first header beat
    assign crc_base = (idx_reg == mbdgs_pkg::IDX_TYPE) ? mbdgs_pkg::CRC_PRESET : crc_reg;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (beat && (idx_reg <= mbdgs_pkg::IDX_DATA)) begin
            crc_next = mbdgs_pkg::crc_byte(crc_base, m_out_byte);
        end
        if (load) begin
            busy_next = 1'b1;
            idx_next  = burst.has_hdr ? mbdgs_pkg::IDX_TYPE : mbdgs_pkg::IDX_DATA;
        end else if (beat && last_beat) begin
            busy_next = 1'b0;
        end else if (beat) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= mbdgs_pkg::IDX_TYPE;
            crc_reg  <= mbdgs_pkg::CRC_PRESET;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            desc_reg <= burst;
        end
    end

endmodule

// ===== design/mot_body_data_group_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// mot_body_data_group_segmenter_unit
// The first result beat shows in the cycle after the input beat is taken.
// Each body beat with bytes left yields one result burst: the body byte, led by
// the header on a segment's first byte and followed by the crc on its last; a
// new input beat is taken only as the burst's last beat leaves the result port.
// Reset: synchronous active low; clears segment state and the crc and drops
// any pending burst, max_seg_len returns to 1013.
// ----------------------------------------------------------------------------
module mot_body_data_group_segmenter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [23:0] s_slide_size,
    input  logic [15:0] s_transport_id,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_group_end,
    output logic        m_run_last
);

    localparam int SB = mbdgs_pkg::SIZE_BITS;
    localparam int LB = mbdgs_pkg::SEG_BITS;
    localparam int NB = mbdgs_pkg::SNUM_BITS;

    logic [LB-1:0] max_seg_len_reg;
    logic [3:0]    cont_reg, cont_next;
    logic [SB-1:0] bytes_left_reg, bytes_left_next;
    logic [LB-1:0] seg_pos_reg, seg_pos_next;
    logic [LB-1:0] seg_len_reg, seg_len_next;
    logic [NB-1:0] seg_num_reg, seg_num_next;
    logic [15:0]   tid_reg, tid_next;

    logic              accept;
    logic              load;
    logic              seg_start;
    logic              seg_end;
    logic [LB-1:0]     lim;
    logic [LB-1:0]     len_now;
    logic [LB:0]       pos_inc;
    mbdgs_pkg::burst_t burst;

    assign accept    = s_valid && s_ready;
    assign load      = accept && (s_func == mbdgs_pkg::FUNC_BODY) && (bytes_left_reg != '0);
    assign seg_start = (seg_pos_reg == '0);
    assign lim       = (max_seg_len_reg == '0) ? mbdgs_pkg::SEG_LEN_MIN : max_seg_len_reg;
    assign len_now   = !seg_start ? seg_len_reg :
                       (bytes_left_reg < SB'(lim)) ? LB'(bytes_left_reg) : lim;
    assign pos_inc   = {1'b0, seg_pos_reg} + {{LB{1'b0}}, 1'b1};
    assign seg_end   = (pos_inc >= {1'b0, len_now}) || (bytes_left_reg == SB'(1));

    always_comb begin
        burst.has_hdr = seg_start;
        burst.has_crc = seg_end;
        burst.cont    = cont_reg;
        burst.last    = (bytes_left_reg == SB'(len_now));
        burst.seg_num = seg_num_reg;
        burst.tid     = tid_reg;
        burst.seg_len = len_now;
        burst.data    = s_data_byte;
    end

    always_comb begin
        cont_next       = cont_reg;
        bytes_left_next = bytes_left_reg;
        seg_pos_next    = seg_pos_reg;
        seg_len_next    = seg_len_reg;
        seg_num_next    = seg_num_reg;
        tid_next        = tid_reg;
        if (accept && (s_func == mbdgs_pkg::FUNC_START)) begin
            bytes_left_next = SB'(s_slide_size);
            tid_next        = s_transport_id;
            seg_pos_next    = '0;
            seg_len_next    = '0;
            seg_num_next    = '0;
        end else if (load) begin
            seg_len_next    = len_now;
            bytes_left_next = bytes_left_reg - SB'(1);
            if (seg_start) begin
                cont_next = cont_reg + 4'd1;
            end
            if (seg_end) begin
                seg_pos_next = '0;
                seg_num_next = seg_num_reg + NB'(1);
            end else begin
                seg_pos_next = pos_inc[LB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_seg_len_reg <= mbdgs_pkg::MAX_SEG_RESET;
            cont_reg        <= '0;
            bytes_left_reg  <= '0;
            seg_pos_reg     <= '0;
            seg_len_reg     <= '0;
            seg_num_reg     <= '0;
            tid_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_seg_len_reg <= cfg_wr_data;
            end
            cont_reg       <= cont_next;
            bytes_left_reg <= bytes_left_next;
            seg_pos_reg    <= seg_pos_next;
            seg_len_reg    <= seg_len_next;
            seg_num_reg    <= seg_num_next;
            tid_reg        <= tid_next;
        end
    end

    mbdgs_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .burst       (burst),
        .free        (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_group_end (m_group_end),
        .m_run_last  (m_run_last)
    );

endmodule

// ===== design/mbdgs_checker.sv =====
// ----------------------------------------------------------------------------
// mbdgs_checker
// port-level checks on the segmenter's result channel and input flow control
// ----------------------------------------------------------------------------
module mbdgs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_group_end,
    input logic        m_run_last
);

    // no beat is offered right after reset
    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result beat right after reset");

    // a group always closes a burst
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_group_end |-> m_run_last)
        else $error("group end without run last");

    // input is held off while a result beat stalls
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during output stall");

    // burst done and nothing new taken leaves the port idle
    a_burst_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_run_last && !(s_valid && s_ready) |=> !m_valid)
        else $error("beat after finished burst");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("stalled beat changed");

endmodule

bind mot_body_data_group_segmenter_unit mbdgs_checker u_mbdgs_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the MOT body data group segmenter. A scoreboard predicts each
// data group byte (header, body, crc) for every accepted beat and checks the
// result stream in order. The run covers directed corner cases and random
// slides under three idling profiles.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       grp_end;
        logic       run_last;
    } dg_beat_t;

    class data_group_checker;
        logic [mbdgs_pkg::SEG_BITS-1:0]  seg_limit;
        logic [3:0]                      cont_index;
        logic [mbdgs_pkg::SIZE_BITS-1:0] bytes_left;
        logic [mbdgs_pkg::SEG_BITS-1:0]  seg_pos;
        logic [mbdgs_pkg::SEG_BITS-1:0]  seg_len_now;
        logic [mbdgs_pkg::SNUM_BITS-1:0] seg_number;
        logic [15:0]                     tid;
        logic [15:0]                     crc;
        dg_beat_t                        expected_bytes[$];
        int                              errors;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            seg_limit   = mbdgs_pkg::MAX_SEG_RESET;
            cont_index  = '0;
            bytes_left  = '0;
            seg_pos     = '0;
            seg_len_now = '0;
            seg_number  = '0;
            tid         = '0;
            crc         = mbdgs_pkg::CRC_PRESET;
            expected_bytes.delete();
        endfunction

        function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic        fb;
            logic [15:0] r;
            r = c;
            for (int i = 7; i >= 0; i--) begin
                fb = r[15] ^ b[i];
                r  = {r[14:0], 1'b0};
                if (fb) begin
                    r = r ^ mbdgs_pkg::CRC_POLY;
                end
            end
            return r;
        endfunction

        function void emit(logic [7:0] b, logic g_end, logic r_last, logic in_crc);
            dg_beat_t e;
            if (in_crc) begin
                crc = crc_update(crc, b);
            end
            e.data     = b;
            e.grp_end  = g_end;
            e.run_last = r_last;
            expected_bytes.insert(expected_bytes.size(), e);
        endfunction

        function void note_beat(logic func, logic [23:0] size, logic [15:0] tid_in,
                                logic [7:0] body);
            logic [mbdgs_pkg::SEG_BITS-1:0] lim;
            logic                           last_seg;
            logic                           seg_done;
            logic [15:0]                    c;
            if (func == mbdgs_pkg::FUNC_START) begin
                bytes_left  = mbdgs_pkg::SIZE_BITS'(size);
                tid         = tid_in;
                seg_pos     = '0;
                seg_len_now = '0;
                seg_number  = '0;
                crc         = mbdgs_pkg::CRC_PRESET;
                return;
            end
            if (bytes_left == 0) begin
                return;
            end
            if (seg_pos == 0) begin
                lim         = (seg_limit == 0) ? mbdgs_pkg::SEG_LEN_MIN : seg_limit;
                seg_len_now = (bytes_left < lim) ? bytes_left[mbdgs_pkg::SEG_BITS-1:0] : lim;
                last_seg    = (bytes_left == seg_len_now);
                crc         = mbdgs_pkg::CRC_PRESET;
                emit(mbdgs_pkg::HDR_TYPE_BYTE, 1'b0, 1'b0, 1'b1);
                emit({cont_index, 4'h0}, 1'b0, 1'b0, 1'b1);
                emit({last_seg, seg_number[14:8]}, 1'b0, 1'b0, 1'b1);
                emit(seg_number[7:0], 1'b0, 1'b0, 1'b1);
                emit(mbdgs_pkg::HDR_EXT_BYTE, 1'b0, 1'b0, 1'b1);
                emit(tid[15:8], 1'b0, 1'b0, 1'b1);
                emit(tid[7:0], 1'b0, 1'b0, 1'b1);
                emit({3'b000, seg_len_now[12:8]}, 1'b0, 1'b0, 1'b1);
                emit(seg_len_now[7:0], 1'b0, 1'b0, 1'b1);
                cont_index = cont_index + 4'd1;
            end
            seg_done = ((seg_pos + 1) >= seg_len_now) || (bytes_left == 1);
            emit(body, 1'b0, !seg_done, 1'b1);
            bytes_left = bytes_left - 1'b1;
            seg_pos    = seg_pos + 1'b1;
            if (seg_done) begin
                c = ~crc;
                emit(c[15:8], 1'b0, 1'b0, 1'b0);
                emit(c[7:0], 1'b1, 1'b1, 1'b0);
                seg_pos    = '0;
                seg_number = seg_number + 1'b1;
                crc        = mbdgs_pkg::CRC_PRESET;
            end
        endfunction

        function void check_byte(logic [7:0] b, logic g_end, logic r_last);
            dg_beat_t e;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected beat: byte %02h group_end %0b run_last %0b",
                             b, g_end, r_last);
                end
                return;
            end
            e = expected_bytes[0];
            expected_bytes.delete(0);
            if (e.data !== b || e.grp_end !== g_end || e.run_last !== r_last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected byte %02h group_end %0b run_last %0b, ",
                             e.data, e.grp_end, e.run_last,
                             "got byte %02h group_end %0b run_last %0b",
                             b, g_end, r_last);
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [12:0] cfg_wr_data    = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_func         = 1'b0;
    logic [23:0] s_slide_size   = '0;
    logic [15:0] s_transport_id = '0;
    logic [7:0]  s_data_byte    = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_group_end;
    logic        m_run_last;

    int send_idle_pct = 8;
    int recv_idle_pct = 59;
    int beats_sent    = 0;

    data_group_checker sb;

    mot_body_data_group_segmenter_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slide_size   (s_slide_size),
        .s_transport_id (s_transport_id),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_group_end    (m_group_end),
        .m_run_last     (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_byte(m_out_byte, m_group_end, m_run_last);
        end
    end

    task automatic drive_beat(logic func, logic [23:0] size, logic [15:0] tid,
                              logic [7:0] body);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_slide_size   <= size;
        s_transport_id <= tid;
        s_data_byte    <= body;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_beat(func, size, tid, body);
        beats_sent++;
    endtask

    task automatic send_start(logic [23:0] size, logic [15:0] tid);
        drive_beat(mbdgs_pkg::FUNC_START, size, tid, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_body(logic [7:0] body);
        drive_beat(mbdgs_pkg::FUNC_BODY, 24'($urandom_range(0, 24'hFFFFFF)),
                   16'($urandom_range(0, 16'hFFFF)), body);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_seg_limit(logic [12:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.seg_limit = v;
    endtask

    task automatic send_random_slide();
        int          r;
        int          nbytes;
        logic [23:0] size;
        r = $urandom_range(99);
        if (r < 8) begin
            send_body(8'($urandom_range(0, 255)));
            return;
        end
        r = $urandom_range(99);
        if (r < 5) begin
            size = '0;
        end else if (r < 15) begin
            size = 24'($urandom_range(0, 24'hFFFFFF));
        end else begin
            size = 24'($urandom_range(1, 12));
        end
        send_start(size, 16'($urandom_range(0, 16'hFFFF)));
        if (size > 12) begin
            nbytes = $urandom_range(0, 5);
        end else if (size != 0 && $urandom_range(99) < 15) begin
            nbytes = $urandom_range(0, size - 1);
        end else begin
            nbytes = size;
        end
        repeat (nbytes) send_body(8'($urandom_range(0, 255)));
    endtask

    task automatic random_phase(int count);
        int target;
        target = beats_sent + count;
        while (beats_sent < target) send_random_slide();
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // sender light, receiver heavy
        send_body(8'hFF);
        send_start(24'd0, 16'hFFFF);
        send_body(8'h00);
        send_start(24'd5, 16'h0000);
        send_body(8'h00);
        send_body(8'hFF);
        send_body(8'h55);
        send_body(8'hAA);
        send_body(8'h01);
        write_seg_limit(13'd3);
        send_start(24'd6, 16'hA5C3);
        repeat (6) send_body(8'($urandom_range(0, 255)));
        send_start(24'd4, 16'h5A3C);
        repeat (2) send_body(8'($urandom_range(0, 255)));
        send_start(24'd2, 16'h1234);
        repeat (2) send_body(8'($urandom_range(0, 255)));
        send_start(24'hFFFFFF, 16'hEDCB);
        send_body(8'h80);
        write_seg_limit(13'd0);
        repeat (3) send_body(8'($urandom_range(0, 255)));
        write_seg_limit(13'd4);
        random_phase(25);

        // sender heavy, receiver light
        wait_drained();
        send_idle_pct = 59;
        recv_idle_pct = 8;
        write_seg_limit(13'd8189);
        random_phase(25);

        // no idling
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seg_limit(13'd2);
        random_phase(25);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mbdgs_pkg.sv
design/mbdgs_emit.sv
design/mot_body_data_group_segmenter_unit.sv
design/mbdgs_checker.sv
test/tb.sv
